/* src/kal_pkg.sv */
package kal_pkg;

  localparam int unsigned DATA_W = 11;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [DATA_W-1:0] NO_NODE          = 11'h7FF;
  localparam logic [DATA_W-1:0] NODE_COUNT_RESET = 11'd1024;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_B_RD0,
    S_B_RD1,
    S_B_WR,
    S_B_WRN,
    S_Q_CHK,
    S_Q_STEP,
    S_Q_WAIT,
    S_Q_FIN,
    S_DONE
  } kal_state_e;

  typedef struct packed {
    logic capture;
    logic wr_load;
    logic rd_mid;
    logic rd_far;
    logic b_write;
    logic b_none;
    logic q_read;
    logic q_take;
    logic q_dec;
    logic q_fail;
    logic q_fin;
    logic out_load;
  } kal_cmd_t;

  typedef struct packed {
    logic [1:0] in_func;
    logic       build_empty;
    logic       q_bad;
    logic       rd_ok;
    logic       last_node;
    logic       last_level;
    logic       bit_set;
    logic       lvl_zero;
    logic       out_free;
  } kal_sts_t;

endpackage

/* src/kal_ctrl.sv */
module kal_ctrl
  import kal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  kal_sts_t sts_i,
  output kal_cmd_t cmd_o,
  output logic     in_stall_o
);

  kal_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          priority if (sts_i.in_func == FUNC_LOAD) begin
            state_d = S_LOAD;
          end else if (sts_i.in_func == FUNC_BUILD) begin
            state_d = sts_i.build_empty ? S_IDLE : S_B_RD0;
          end else if (sts_i.in_func == FUNC_QUERY) begin
            state_d = S_Q_CHK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.wr_load = 1'b1;
        state_d       = S_IDLE;
      end
      S_B_RD0: begin
        cmd_o.rd_mid = 1'b1;
        state_d      = S_B_RD1;
      end
      S_B_RD1: begin
        if (sts_i.rd_ok) begin
          cmd_o.rd_far = 1'b1;
          state_d      = S_B_WR;
        end else begin
          state_d = S_B_WRN;
        end
      end
      S_B_WR, S_B_WRN: begin
        cmd_o.b_write = 1'b1;
        cmd_o.b_none  = (state_q == S_B_WRN);
        state_d       = (sts_i.last_node && sts_i.last_level) ? S_IDLE : S_B_RD0;
      end
      S_Q_CHK: begin
        if (sts_i.q_bad) begin
          cmd_o.q_fail = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_Q_STEP;
        end
      end
      S_Q_STEP: begin
        if (sts_i.bit_set) begin
          cmd_o.q_read = 1'b1;
          state_d      = S_Q_WAIT;
        end else if (sts_i.lvl_zero) begin
          state_d = S_Q_FIN;
        end else begin
          cmd_o.q_dec = 1'b1;
        end
      end
      S_Q_WAIT: begin
        if (!sts_i.rd_ok) begin
          cmd_o.q_fail = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.q_take = 1'b1;
          cmd_o.q_dec  = !sts_i.lvl_zero;
          state_d      = sts_i.lvl_zero ? S_Q_FIN : S_Q_STEP;
        end
      end
      S_Q_FIN: begin
        cmd_o.q_fin = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded into busy output register");

  a_far_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_far |-> sts_i.rd_ok)
    else $error("build follows an absent ancestor");

  a_query_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.capture && sts_i.in_func == FUNC_QUERY) |=> state_q == S_Q_CHK)
    else $error("query beat not dispatched");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.rd_mid, cmd_o.rd_far, cmd_o.q_read, cmd_o.wr_load,
                cmd_o.b_write}) <= 1)
    else $error("table accessed twice in one cycle");

endmodule

/* src/kal_dpath.sv */
module kal_dpath
  import kal_pkg::*;
#(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned LEVELS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kal_cmd_t                 cmd_i,
  output kal_sts_t                 sts_o,
  input  logic                     cfg_valid_i,
  input  logic [DATA_W-1:0]        cfg_node_count_i,
  input  logic [1:0]               func_i,
  input  logic [9:0]               node_i,
  input  logic signed [DATA_W-1:0] parent_of_node_i,
  input  logic [9:0]               steps_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] ancestor_o
);

  localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned AW    = LW + NW;
  localparam int unsigned DEPTH = LEVELS * (2 ** NW);
  localparam int unsigned CW    = ((NW > DATA_W) ? NW : DATA_W) + 1;

  localparam logic [DATA_W-1:0] CAP     = (NODES > 2047) ? 11'h7FF : DATA_W'(NODES);
  localparam logic [CW-1:0]     NODES_C = CW'(NODES);
  localparam logic [LW-1:0]     LVL_TOP = LW'(LEVELS - 1);

  function automatic logic [NW-1:0] to_idx(input logic [DATA_W-1:0] v);
    logic [NW+DATA_W-1:0] w;
    w = {{NW{1'b0}}, v};
    return w[NW-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_data(input logic [NW-1:0] v);
    logic [NW+DATA_W-1:0] w;
    w = {{DATA_W{1'b0}}, v};
    return w[DATA_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];

  logic [DATA_W-1:0] node_count_q;
  logic [1:0]        func_q;
  logic [9:0]        node_q;
  logic [DATA_W-1:0] parent_q;
  logic [9:0]        steps_q;
  logic [NW-1:0]     bi_q;
  logic [LW-1:0]     bj_q;
  logic [NW-1:0]     cur_q;
  logic [LW-1:0]     lvl_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] anc_q;
  logic              out_valid_q;

  logic [DATA_W-1:0]   eff;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [LEVELS+9:0]   steps_x;
  logic [(2**LW)-1:0]  steps_l;

  assign eff     = (node_count_q < CAP) ? node_count_q : CAP;
  assign steps_x = {{LEVELS{1'b0}}, steps_q};
  assign steps_l = steps_x[(2**LW)-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_node_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      node_q   <= node_i;
      parent_q <= $unsigned(parent_of_node_i);
      steps_q  <= steps_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bi_q <= '0;
      bj_q <= LW'(1);
    end else if (cmd_i.b_write) begin
      if (sts_o.last_node) begin
        bi_q <= '0;
        bj_q <= bj_q + LW'(1);
      end else begin
        bi_q <= bi_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_q <= to_idx({1'b0, node_i});
      lvl_q <= LVL_TOP;
    end else begin
      if (cmd_i.q_take) begin
        cur_q <= to_idx(rd_data_q);
      end
      if (cmd_i.q_dec) begin
        lvl_q <= lvl_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_fail) begin
      res_q <= NO_NODE;
    end else if (cmd_i.q_fin) begin
      res_q <= to_data(cur_q);
    end
  end

  always_comb begin
    rd_en   = cmd_i.rd_mid || cmd_i.rd_far || cmd_i.q_read;
    rd_addr = {lvl_q, cur_q};
    if (cmd_i.rd_mid) begin
      rd_addr = {bj_q - LW'(1), bi_q};
    end else if (cmd_i.rd_far) begin
      rd_addr = {bj_q - LW'(1), to_idx(rd_data_q)};
    end
  end

  always_comb begin
    wr_en   = cmd_i.b_write || (cmd_i.wr_load && (CW'(node_q) < NODES_C));
    wr_addr = {bj_q, bi_q};
    wr_data = cmd_i.b_none ? NO_NODE : rd_data_q;
    if (cmd_i.wr_load) begin
      wr_addr = {LW'(0), to_idx({1'b0, node_q})};
      wr_data = parent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      anc_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ancestor_o  = $signed(anc_q);

  always_comb begin
    sts_o.in_func     = func_i;
    sts_o.build_empty = (eff == '0) || (LEVELS == 1);
    sts_o.q_bad       = !(CW'(node_q) < CW'(eff)) || ((steps_q >> LEVELS) != '0)
                        || (func_q != FUNC_QUERY);
    sts_o.rd_ok       = !rd_data_q[DATA_W-1] && (rd_data_q < eff);
    sts_o.last_node   = (CW'(bi_q) + CW'(1)) == CW'(eff);
    sts_o.last_level  = (bj_q == LVL_TOP);
    sts_o.bit_set     = steps_l[lvl_q];
    sts_o.lvl_zero    = (lvl_q == '0);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule

/* src/kth_ancestor_binary_lifting.sv */
// k-th ancestor lookup over a binary-lifting jump table.
// Input channel (in_valid_i / in_stall_o) carries one beat per command:
//   func 0 loads the parent of node (level 0 of the table), func 1 builds
//   levels 1..LEVELS-1, func 2 queries the steps-th ancestor of node.
//   func 3 is dropped. Only a query produces an output beat.
// Output channel (out_valid_o / out_stall_i) carries ancestor, -1 if none.
// Config channel (cfg_valid_i / cfg_ready_o, always ready) writes
//   node_count; write it only while no command is in flight.
// Sequencing, set by the single-port table memory with registered read data:
//   load    writes the parent into level 0 of the table.
//   build   eff * (LEVELS-1) entries, eff = min(node_count, NODES); each
//           reads its mid entry, the far one if valid, then writes.
//   query   checks the command, then walks down the levels: a clear step bit
//           only steps down, a set bit reads, then checks the read.
// The output register frees the core: the next command is taken while a
// result waits. A new query finishing while the output is still stalled
// holds in its last state until the register drains.
// Reset returns the controller to idle and node_count to 1024. Table
// contents are not cleared; entries read before being written are garbage.
module kth_ancestor_binary_lifting
  import kal_pkg::*;
#(
  parameter int unsigned NODES  = 1024,
  parameter int unsigned LEVELS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [DATA_W-1:0]        cfg_node_count_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic [9:0]               node_i,
  input  logic signed [DATA_W-1:0] parent_of_node_i,
  input  logic [9:0]               steps_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] ancestor_o
);

  kal_cmd_t cmd;
  kal_sts_t sts;

  assign cfg_ready_o = 1'b1;

  kal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  kal_dpath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_node_count_i (cfg_node_count_i),
    .func_i           (func_i),
    .node_i           (node_i),
    .parent_of_node_i (parent_of_node_i),
    .steps_i          (steps_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .ancestor_o       (ancestor_o)
  );

endmodule
